// File: rtl/jcsd_pkg.sv
`default_nettype none

package jcsd_pkg;

	typedef enum logic [1:0] {
		OP_BEGIN       = 2'd0,
		OP_SAMPLE      = 2'd1,
		OP_MEASURE     = 2'd2,
		OP_MEASURE_ALT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		DIR_NEUTRAL = 3'd0,
		DIR_LEFT    = 3'd1,
		DIR_UP      = 3'd2,
		DIR_RIGHT   = 3'd3,
		DIR_DOWN    = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_SAT,
		ST_SQR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic sat;
		logic sqr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic measure;
		logic out_free;
	} status_t;

	localparam logic [6:0]  FULL_SCALE   = 7'd100;
	localparam logic [6:0]  DEADBAND     = 7'd4;
	localparam logic [14:0] MAG_LIMIT_SQ = 15'd6561;
	localparam logic [3:0]  DIV_STEPS    = 4'd15;
	localparam logic [7:0]  RST_LOW      = 8'd0;
	localparam logic [7:0]  RST_CENTRE   = 8'd127;
	localparam logic [7:0]  RST_HIGH     = 8'd255;
	localparam logic [7:0]  CAL_LOW      = 8'd255;
	localparam logic [7:0]  CAL_HIGH     = 8'd0;

endpackage

`default_nettype wire

// File: rtl/jcsd_axis.sv
`default_nettype none

module jcsd_axis (
	input  wire logic              clk,
	input  wire jcsd_pkg::cmd_t    cmd,
	input  wire logic [7:0]        v,
	input  wire logic [7:0]        lo,
	input  wire logic [7:0]        c,
	input  wire logic [7:0]        hi,
	output logic signed [7:0]      s
);

	logic [8:0]  diff;
	logic [8:0]  span;
	logic [7:0]  diff_mag;
	logic [7:0]  span_mag;
	logic [14:0] num_mag;
	logic [8:0]  trial;
	logic        fits;
	logic [6:0]  mag;
	logic [6:0]  mag_db;

	logic        neg_q;
	logic        zero_q;
	logic [7:0]  dmag_q;
	logic [7:0]  rem_q;
	logic [14:0] quo_q;
	logic [7:0]  s_q;

	always_comb begin
		diff     = {1'b0, v} - {1'b0, c};
		span     = (v > c) ? ({1'b0, hi} - {1'b0, c}) : ({1'b0, c} - {1'b0, lo});
		diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
		span_mag = span[8] ? 8'(-span) : span[7:0];
		num_mag  = 15'(diff_mag) * 15'(jcsd_pkg::FULL_SCALE);
	end

	// restoring divider, one quotient bit per step
	always_comb begin
		trial = {rem_q, quo_q[14]};
		fits  = trial >= {1'b0, dmag_q};
	end

	always_comb begin
		mag    = (quo_q > 15'(jcsd_pkg::FULL_SCALE)) ? jcsd_pkg::FULL_SCALE : quo_q[6:0];
		mag_db = (zero_q || mag < jcsd_pkg::DEADBAND) ? 7'd0 : mag;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			neg_q  <= diff[8] ^ span[8];
			zero_q <= (span == 9'd0);
			dmag_q <= span_mag;
			rem_q  <= 8'd0;
			quo_q  <= num_mag;
		end
		if (cmd.step) begin
			rem_q <= fits ? 8'(trial - {1'b0, dmag_q}) : trial[7:0];
			quo_q <= {quo_q[13:0], fits};
		end
		if (cmd.sat) begin
			s_q <= neg_q ? 8'(-{1'b0, mag_db}) : {1'b0, mag_db};
		end
	end

	assign s = s_q;

endmodule

`default_nettype wire

// File: rtl/jcsd_ctrl.sv
`default_nettype none

module jcsd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire jcsd_pkg::status_t  status,
	output jcsd_pkg::cmd_t          cmd,
	output logic                    busy
);

	jcsd_pkg::state_t state_q;
	jcsd_pkg::state_t state_d;
	logic [3:0]       cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			jcsd_pkg::ST_IDLE: begin
				if (in_valid) state_d = jcsd_pkg::ST_PREP;
			end
			jcsd_pkg::ST_PREP: begin
				state_d = status.measure ? jcsd_pkg::ST_DIV : jcsd_pkg::ST_EMIT;
			end
			jcsd_pkg::ST_DIV: begin
				if (cnt_q == jcsd_pkg::DIV_STEPS - 4'd1) state_d = jcsd_pkg::ST_SAT;
			end
			jcsd_pkg::ST_SAT:  state_d = jcsd_pkg::ST_SQR;
			jcsd_pkg::ST_SQR:  state_d = jcsd_pkg::ST_EMIT;
			jcsd_pkg::ST_EMIT: begin
				if (status.out_free) state_d = jcsd_pkg::ST_IDLE;
			end
			default: state_d = jcsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == jcsd_pkg::ST_IDLE) && in_valid;
		cmd.prep = (state_q == jcsd_pkg::ST_PREP);
		cmd.step = (state_q == jcsd_pkg::ST_DIV);
		cmd.sat  = (state_q == jcsd_pkg::ST_SAT);
		cmd.sqr  = (state_q == jcsd_pkg::ST_SQR);
		cmd.emit = (state_q == jcsd_pkg::ST_EMIT) && status.out_free;
		busy     = (state_q != jcsd_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jcsd_pkg::ST_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			if (state_q == jcsd_pkg::ST_PREP) cnt_q <= 4'd0;
			else if (state_q == jcsd_pkg::ST_DIV) cnt_q <= cnt_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/jcsd_dpath.sv
`default_nettype none

module jcsd_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire jcsd_pkg::cmd_t     cmd,
	output jcsd_pkg::status_t       status,
	input  wire logic [1:0]         op,
	input  wire logic [7:0]         x_raw,
	input  wire logic [7:0]         y_raw,
	input  wire logic               button,
	input  wire logic [7:0]         slider_raw,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [7:0]       x_scaled,
	output logic signed [7:0]       y_scaled,
	output logic                    pressed,
	output logic [7:0]              slider,
	output logic [2:0]              direction
);

	jcsd_pkg::op_t    op_q;
	logic [7:0]       xr_q;
	logic [7:0]       yr_q;
	logic             btn_q;
	logic [7:0]       sl_q;

	logic [7:0]       x_low_q, x_centre_q, x_high_q;
	logic [7:0]       y_low_q, y_centre_q, y_high_q;

	logic signed [7:0]  xs;
	logic signed [7:0]  ys;
	logic signed [15:0] sqx;
	logic signed [15:0] sqy;
	logic [14:0]        sqx_q;
	logic [14:0]        sqy_q;
	logic [15:0]        mag_sq;
	logic signed [8:0]  xe, ye, nx;
	jcsd_pkg::dir_t     dir;
	logic               measure;

	logic               out_valid_q;
	logic [7:0]         xo_q, yo_q, slo_q;
	logic               po_q;
	logic [2:0]         diro_q;

	assign measure = (op_q != jcsd_pkg::OP_BEGIN) && (op_q != jcsd_pkg::OP_SAMPLE);
	assign status  = '{measure: measure, out_free: (!out_valid_q || !out_stall)};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= jcsd_pkg::op_t'(op);
			xr_q  <= x_raw;
			yr_q  <= y_raw;
			btn_q <= button;
			sl_q  <= slider_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q    <= jcsd_pkg::RST_LOW;
			x_centre_q <= jcsd_pkg::RST_CENTRE;
			x_high_q   <= jcsd_pkg::RST_HIGH;
			y_low_q    <= jcsd_pkg::RST_LOW;
			y_centre_q <= jcsd_pkg::RST_CENTRE;
			y_high_q   <= jcsd_pkg::RST_HIGH;
		end else if (cmd.prep) begin
			case (op_q)
				jcsd_pkg::OP_BEGIN: begin
					x_centre_q <= xr_q;
					y_centre_q <= yr_q;
					x_low_q    <= jcsd_pkg::CAL_LOW;
					y_low_q    <= jcsd_pkg::CAL_LOW;
					x_high_q   <= jcsd_pkg::CAL_HIGH;
					y_high_q   <= jcsd_pkg::CAL_HIGH;
				end
				jcsd_pkg::OP_SAMPLE: begin
					if (xr_q > x_high_q) x_high_q <= xr_q;
					if (yr_q > y_high_q) y_high_q <= yr_q;
					if (xr_q < x_low_q)  x_low_q  <= xr_q;
					if (yr_q < y_low_q)  y_low_q  <= yr_q;
				end
				default: ;
			endcase
		end
	end

	jcsd_axis u_axis_x (
		.clk (clk),
		.cmd (cmd),
		.v   (xr_q),
		.lo  (x_low_q),
		.c   (x_centre_q),
		.hi  (x_high_q),
		.s   (xs)
	);

	jcsd_axis u_axis_y (
		.clk (clk),
		.cmd (cmd),
		.v   (yr_q),
		.lo  (y_low_q),
		.c   (y_centre_q),
		.hi  (y_high_q),
		.s   (ys)
	);

	assign sqx = xs * xs;
	assign sqy = ys * ys;

	always_ff @(posedge clk) begin
		if (cmd.sqr) begin
			sqx_q <= sqx[14:0];
			sqy_q <= sqy[14:0];
		end
	end

	// sector tests against the diagonals y = x and y = -x
	always_comb begin
		mag_sq = 16'(sqx_q) + 16'(sqy_q);
		xe     = {xs[7], xs};
		ye     = {ys[7], ys};
		nx     = -xe;
		if (mag_sq < 16'(jcsd_pkg::MAG_LIMIT_SQ))   dir = jcsd_pkg::DIR_NEUTRAL;
		else if (ye > xe && ye >= nx)               dir = jcsd_pkg::DIR_UP;
		else if (ye <= xe && ye > nx)               dir = jcsd_pkg::DIR_RIGHT;
		else if (ye < xe && ye <= nx)               dir = jcsd_pkg::DIR_DOWN;
		else                                        dir = jcsd_pkg::DIR_LEFT;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			xo_q   <= measure ? xs : 8'sd0;
			yo_q   <= measure ? ys : 8'sd0;
			diro_q <= measure ? dir : jcsd_pkg::DIR_NEUTRAL;
			po_q   <= btn_q;
			slo_q  <= sl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign x_scaled  = xo_q;
	assign y_scaled  = yo_q;
	assign pressed   = po_q;
	assign slider    = slo_q;
	assign direction = diro_q;

endmodule

`default_nettype wire

// File: rtl/joystick_calibrate_scale_direction_core.sv
// channel  valid      stall      payload
// in       in_valid   in_stall   op, x_raw, y_raw, button, slider_raw
// out      out_valid  out_stall  x_scaled, y_scaled, pressed, slider, direction
//
// Measure item: after acceptance it passes PREP, the 15-step restoring divider
// (one per axis, run side by side), SAT, SQR and EMIT, then the next is taken.
// Calibration item: PREP, then EMIT; EMIT waits while the output register is held.
// One item in flight; in_stall is high while busy.
// A result waits in the output register; the next item is taken meanwhile.
// arst_n clears control state and loads the default calibration.
`default_nettype none

module joystick_calibrate_scale_direction_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   op,
	input  wire logic [7:0]   x_raw,
	input  wire logic [7:0]   y_raw,
	input  wire logic         button,
	input  wire logic [7:0]   slider_raw,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic signed [7:0] x_scaled,
	output logic signed [7:0] y_scaled,
	output logic              pressed,
	output logic [7:0]        slider,
	output logic [2:0]        direction
);

	jcsd_pkg::cmd_t    cmd;
	jcsd_pkg::status_t status;
	logic              busy;

	jcsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	jcsd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.x_raw      (x_raw),
		.y_raw      (y_raw),
		.button     (button),
		.slider_raw (slider_raw),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.x_scaled   (x_scaled),
		.y_scaled   (y_scaled),
		.pressed    (pressed),
		.slider     (slider),
		.direction  (direction)
	);

	assign in_stall = busy;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not make the block busy");

	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_scaled <= 8'sd100 && x_scaled >= -8'sd100 &&
		               y_scaled <= 8'sd100 && y_scaled >= -8'sd100))
		else $error("scaled value out of range");

	a_dir_needs_deflection: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && direction != 3'(jcsd_pkg::DIR_NEUTRAL)) |->
		(x_scaled != 8'sd0 || y_scaled != 8'sd0))
		else $error("direction given for centred stick");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (direction <= 3'(jcsd_pkg::DIR_DOWN)))
		else $error("direction code out of range");
`endif

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;

	localparam int PCT_FULL     = int'(jcsd_pkg::FULL_SCALE);
	localparam int PCT_DEAD     = int'(jcsd_pkg::DEADBAND);
	localparam int MAG_SQ       = int'(jcsd_pkg::MAG_LIMIT_SQ);
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;

	typedef struct {
		logic signed [7:0] xs;
		logic signed [7:0] ys;
		logic              pr;
		logic [7:0]        sl;
		jcsd_pkg::dir_t    dir;
	} reading_t;

	typedef struct {
		jcsd_pkg::op_t op;
		logic [7:0]    x;
		logic [7:0]    y;
		logic          btn;
		logic [7:0]    sl;
		bit            known;
		reading_t      want;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = jcsd_pkg::OP_BEGIN;
	logic [7:0] x_raw = 8'd0;
	logic [7:0] y_raw = 8'd0;
	logic button = 1'b0;
	logic [7:0] slider_raw = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [7:0] x_scaled;
	logic signed [7:0] y_scaled;
	logic pressed;
	logic [7:0] slider;
	logic [2:0] direction;

	joystick_calibrate_scale_direction_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.x_raw(x_raw),
		.y_raw(y_raw),
		.button(button),
		.slider_raw(slider_raw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_scaled(x_scaled),
		.y_scaled(y_scaled),
		.pressed(pressed),
		.slider(slider),
		.direction(direction)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// calibration as the block should hold it
	logic [7:0] x_lo = jcsd_pkg::RST_LOW, x_mid = jcsd_pkg::RST_CENTRE, x_hi = jcsd_pkg::RST_HIGH;
	logic [7:0] y_lo = jcsd_pkg::RST_LOW, y_mid = jcsd_pkg::RST_CENTRE, y_hi = jcsd_pkg::RST_HIGH;

	sample_item_t items[$];
	reading_t     readings_due[$];
	int errors = 0, checked = 0, taken = 0, n_measure = 0, n_moved = 0;
	bit calm = 1'b0;

	function automatic int axis_pct(int v, int lo, int c, int hi);
		int span, s;
		span = (v > c) ? hi - c : c - lo;
		if (span == 0)
			return 0;
		s = (v - c) * PCT_FULL / span;
		if (s > PCT_FULL)
			s = PCT_FULL;
		if (s < -PCT_FULL)
			s = -PCT_FULL;
		if (s < PCT_DEAD && s > -PCT_DEAD)
			s = 0;
		return s;
	endfunction

	function automatic jcsd_pkg::dir_t heading(int x, int y);
		if (x * x + y * y < MAG_SQ)
			return jcsd_pkg::DIR_NEUTRAL;
		if (y > x && y >= -x)
			return jcsd_pkg::DIR_UP;
		if (y <= x && y > -x)
			return jcsd_pkg::DIR_RIGHT;
		if (y < x && y <= -x)
			return jcsd_pkg::DIR_DOWN;
		return jcsd_pkg::DIR_LEFT;
	endfunction

	function automatic reading_t calibrated_reading(sample_item_t s);
		reading_t r;
		int xs, ys;
		xs = 0;
		ys = 0;
		r.dir = jcsd_pkg::DIR_NEUTRAL;
		case (s.op)
			jcsd_pkg::OP_BEGIN: begin
				x_mid = s.x;
				y_mid = s.y;
				x_lo = jcsd_pkg::CAL_LOW;
				y_lo = jcsd_pkg::CAL_LOW;
				x_hi = jcsd_pkg::CAL_HIGH;
				y_hi = jcsd_pkg::CAL_HIGH;
			end
			jcsd_pkg::OP_SAMPLE: begin
				if (s.x > x_hi) x_hi = s.x;
				if (s.y > y_hi) y_hi = s.y;
				if (s.x < x_lo) x_lo = s.x;
				if (s.y < y_lo) y_lo = s.y;
			end
			default: begin
				xs = axis_pct(int'(s.x), int'(x_lo), int'(x_mid), int'(x_hi));
				ys = axis_pct(int'(s.y), int'(y_lo), int'(y_mid), int'(y_hi));
				r.dir = heading(xs, ys);
			end
		endcase
		r.xs = 8'(xs);
		r.ys = 8'(ys);
		r.pr = s.btn;
		r.sl = s.sl;
		return r;
	endfunction

	task automatic add_row(jcsd_pkg::op_t o, int x, int y, bit b, int s,
			bit known, int xs, int ys, jcsd_pkg::dir_t d);
		sample_item_t t;
		t.op = o;
		t.x = 8'(x);
		t.y = 8'(y);
		t.btn = b;
		t.sl = 8'(s);
		t.known = known;
		t.want.xs = 8'(xs);
		t.want.ys = 8'(ys);
		t.want.pr = b;
		t.want.sl = 8'(s);
		t.want.dir = d;
		items.push_back(t);
	endtask

	task automatic add_random(jcsd_pkg::op_t o, int x, int y);
		add_row(o, x, y, 1'($urandom_range(1)), int'($urandom_range(255)), 1'b0, 0, 0,
			jcsd_pkg::DIR_NEUTRAL);
	endtask

	function automatic logic [7:0] raw_sample();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] jitter(int c, int r);
		int v;
		v = c + int'($urandom_range(2 * r)) - r;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	// input side: predict each accepted item
	always @(posedge clk) begin
		reading_t r;
		if (arst_n && in_valid && !in_stall) begin
			r = calibrated_reading(items[taken]);
			if (items[taken].known)
				r = items[taken].want;
			if (items[taken].op != jcsd_pkg::OP_BEGIN && items[taken].op != jcsd_pkg::OP_SAMPLE)
				n_measure++;
			if (r.dir != jcsd_pkg::DIR_NEUTRAL)
				n_moved++;
			readings_due.push_back(r);
			taken++;
		end
	end

	// output side: compare with oldest expectation
	always @(posedge clk) begin
		reading_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				w = readings_due.pop_front();
				if (x_scaled !== w.xs) begin
					$error("x_scaled: expected %0d, got %0d", w.xs, x_scaled);
					errors++;
				end
				if (y_scaled !== w.ys) begin
					$error("y_scaled: expected %0d, got %0d", w.ys, y_scaled);
					errors++;
				end
				if (pressed !== w.pr) begin
					$error("pressed: expected %0d, got %0d", w.pr, pressed);
					errors++;
				end
				if (slider !== w.sl) begin
					$error("slider: expected %0d, got %0d", w.sl, slider);
					errors++;
				end
				if (direction !== w.dir) begin
					$error("direction: expected %0d, got %0d", w.dir, direction);
					errors++;
				end
				checked++;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && taken >= 500) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else
				out_stall <= !calm && ($urandom_range(99) < 9);
		end
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		int i, k, cx, cy;

		// default calibration after reset
		add_row(jcsd_pkg::OP_MEASURE, 255, 127, 1, 255, 1, 100, 0, jcsd_pkg::DIR_RIGHT);
		add_row(jcsd_pkg::OP_MEASURE, 0, 127, 0, 0, 1, -100, 0, jcsd_pkg::DIR_LEFT);
		add_row(jcsd_pkg::OP_MEASURE_ALT, 127, 255, 1, 8'h80, 1, 0, 100, jcsd_pkg::DIR_UP);
		add_row(jcsd_pkg::OP_MEASURE, 127, 0, 0, 8'h7f, 1, 0, -100, jcsd_pkg::DIR_DOWN);
		add_row(jcsd_pkg::OP_MEASURE, 127, 127, 1, 1, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 255, 255, 0, 8'h33, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 130, 124, 1, 8'hcc, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 133, 121, 0, 8'h5a, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 0, 0, 1, 8'ha5, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		// begin only: spans come out inverted
		add_row(jcsd_pkg::OP_BEGIN, 100, 150, 1, 8'haa, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 200, 200, 0, 8'h01, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 20, 90, 1, 8'h02, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 100, 150, 0, 8'h04, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		// sample at centre: zero spans
		add_row(jcsd_pkg::OP_SAMPLE, 100, 150, 1, 8'h55, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 200, 10, 1, 8'h08, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_SAMPLE, 0, 0, 0, 0, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_SAMPLE, 255, 255, 1, 255, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 0, 255, 0, 8'h10, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 255, 0, 1, 8'h20, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		// centres at the rails
		add_row(jcsd_pkg::OP_BEGIN, 0, 255, 0, 0, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_SAMPLE, 0, 255, 1, 8'h0f, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE_ALT, 0, 255, 0, 8'h40, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 255, 0, 1, 8'hfe, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_SAMPLE, 255, 0, 0, 8'hf0, 1, 0, 0, jcsd_pkg::DIR_NEUTRAL);
		add_row(jcsd_pkg::OP_MEASURE, 255, 0, 1, 8'h7e, 0, 0, 0, jcsd_pkg::DIR_NEUTRAL);

		k = items.size() + RANDOM_ITEMS;
		while (items.size() < k) begin
			if ($urandom_range(99) < 85) begin
				cx = ($urandom_range(3) == 0) ? int'($urandom_range(255))
					: int'($urandom_range(195, 60));
				cy = ($urandom_range(3) == 0) ? int'($urandom_range(255))
					: int'($urandom_range(195, 60));
				add_random(jcsd_pkg::OP_BEGIN, cx, cy);
				repeat ($urandom_range(6))
					add_random(jcsd_pkg::OP_SAMPLE, int'(jitter(cx, 127)),
						int'(jitter(cy, 127)));
				repeat ($urandom_range(20, 5)) begin
					if ($urandom_range(1))
						add_random(($urandom_range(4) == 0) ? jcsd_pkg::OP_MEASURE_ALT
							: jcsd_pkg::OP_MEASURE,
							int'(jitter(cx, 10)), int'(jitter(cy, 10)));
					else
						add_random(($urandom_range(4) == 0) ? jcsd_pkg::OP_MEASURE_ALT
							: jcsd_pkg::OP_MEASURE,
							int'(raw_sample()), int'(raw_sample()));
				end
			end else
				add_random(jcsd_pkg::op_t'($urandom_range(3)), int'(raw_sample()),
					int'(raw_sample()));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < items.size(); i++) begin
			calm = (i >= 800 && i < 1100);
			@(negedge clk);
			while (!calm && $urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			op <= items[i].op;
			x_raw <= items[i].x;
			y_raw <= items[i].y;
			button <= items[i].btn;
			slider_raw <= items[i].sl;
			do
				@(posedge clk);
			while (in_stall);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		calm = 1'b0;

		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent (%0d measures, rest calibration), %0d results checked",
			taken, n_measure, checked);
		$display("%0d readings left neutral, %0d with a direction", checked - n_moved, n_moved);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/jcsd_pkg.sv
rtl/jcsd_axis.sv
rtl/jcsd_ctrl.sv
rtl/jcsd_dpath.sv
rtl/joystick_calibrate_scale_direction_core.sv
sim/tb_top.sv
